// ===== rtl/tlrus_pkg.sv =====
// ----------------------------------------------------------------------------
// tlrus_pkg
// Shared types and constants for the true LRU replacement stack.
// ----------------------------------------------------------------------------
`default_nettype none

package tlrus_pkg;

	localparam int SET_W = 10;  // width of the set_index field
	localparam int WAY_W = 4;   // width of the way and victim_way fields
	localparam int POS_W = 4;   // width of one stack position in a row

	localparam int DEF_NUM_SETS = 1024;
	localparam int DEF_ASSOC    = 16;

	localparam logic MODE_QUERY = 1'b0;
	localparam logic MODE_TOUCH = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BUSY
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/tlrus_ram.sv =====
// ----------------------------------------------------------------------------
// tlrus_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tlrus_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/true_lru_stack_replacement_top.sv =====
// ----------------------------------------------------------------------------
// true_lru_stack_replacement_top
// True LRU replacement stack: per-set recency rows in a RAM, read-modify-write.
// ----------------------------------------------------------------------------
// Each set keeps one row of ASSOC stack positions (0 = most recent) in a
// single RAM with a registered read. An item is taken in the idle state
// (the row is read) and finished in the busy state (a touch writes the
// updated row back, a victim query loads the result register), so the
// block takes no new item until the last one has finished. A query whose
// result register is still full waits in the busy state until the result
// transfers. After reset the block runs a clearing pass that writes the
// initial stack (way w at position w) into every row; in_ready stays low
// until it ends. A touch of an out-of-range set or way changes nothing,
// and a query of an out-of-range set answers way 0.
`default_nettype none

module true_lru_stack_replacement_top #(
	parameter int NUM_SETS = tlrus_pkg::DEF_NUM_SETS,
	parameter int ASSOC    = tlrus_pkg::DEF_ASSOC
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        mode,
	input  wire logic [tlrus_pkg::SET_W-1:0] set_index,
	input  wire logic [tlrus_pkg::WAY_W-1:0] way,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [tlrus_pkg::WAY_W-1:0] victim_way
);

	localparam int AW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int PW    = tlrus_pkg::POS_W;
	localparam int ROW_W = ASSOC * PW;

	function automatic logic [ROW_W-1:0] init_row();
		logic [ROW_W-1:0] r;
		r = '0;
		for (int w = 0; w < ASSOC; w++) begin
			r[w*PW +: PW] = PW'(w);
		end
		return r;
	endfunction

	tlrus_pkg::state_t state_q, state_d;

	logic [AW-1:0]                 clr_q;
	logic                          clr_last;
	logic                          in_xfer;
	logic                          done_s1;

	logic [31:0]                   set_ext;
	logic [AW-1:0]                 addr_in;
	logic                          set_ok_in;

	logic                          mode_s1;
	logic                          set_ok_s1;
	logic [tlrus_pkg::WAY_W-1:0]   way_s1;
	logic [AW-1:0]                 addr_s1;

	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [ROW_W-1:0]              ram_wdata;
	logic [ROW_W-1:0]              row_rd;

	logic [ROW_W-1:0]              row_new;
	logic [PW-1:0]                 cur_pos;
	logic                          way_ok;
	logic [tlrus_pkg::WAY_W-1:0]   victim_d;
	logic                          found;

	logic                          out_valid_q;
	logic [tlrus_pkg::WAY_W-1:0]   victim_q;

	assign set_ext   = 32'(set_index);
	assign addr_in   = set_ext[AW-1:0];
	assign set_ok_in = set_ext < 32'(NUM_SETS);
	assign clr_last  = clr_q == AW'(NUM_SETS - 1);
	assign in_xfer   = in_valid && in_ready;

	// a query must find the result register free (or draining) to finish
	assign done_s1 = (state_q == tlrus_pkg::ST_BUSY) &&
		((mode_s1 == tlrus_pkg::MODE_TOUCH) || !out_valid_q || out_ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tlrus_pkg::ST_CLEAR: begin
				if (clr_last) begin
					state_d = tlrus_pkg::ST_IDLE;
				end
			end
			tlrus_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = tlrus_pkg::ST_BUSY;
				end
			end
			tlrus_pkg::ST_BUSY: begin
				if (done_s1) begin
					state_d = tlrus_pkg::ST_IDLE;
				end
			end
			default: state_d = tlrus_pkg::ST_CLEAR;
		endcase
	end

	// outputs of the control
	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = row_new;
		unique case (state_q)
			tlrus_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = init_row();
			end
			tlrus_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			tlrus_pkg::ST_BUSY: begin
				ram_we = done_s1 && (mode_s1 == tlrus_pkg::MODE_TOUCH) &&
					set_ok_s1 && way_ok;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlrus_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == tlrus_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	// hold the item while its row is read
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_s1   <= mode;
			set_ok_s1 <= set_ok_in;
			way_s1    <= way;
			addr_s1   <= addr_in;
		end
	end

	tlrus_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_SETS)
	) u_rows (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_xfer),
		.raddr (addr_in),
		.rdata (row_rd)
	);

	// touch: move the way to the top, age every more recent way by one
	always_comb begin
		way_ok  = 32'(way_s1) < 32'(ASSOC);
		cur_pos = '0;
		for (int w = 0; w < ASSOC; w++) begin
			if (way_s1 == tlrus_pkg::WAY_W'(w)) begin
				cur_pos = row_rd[w*PW +: PW];
			end
		end
		row_new = row_rd;
		for (int w = 0; w < ASSOC; w++) begin
			if (way_s1 == tlrus_pkg::WAY_W'(w)) begin
				row_new[w*PW +: PW] = '0;
			end else if (row_rd[w*PW +: PW] < cur_pos) begin
				row_new[w*PW +: PW] = row_rd[w*PW +: PW] + PW'(1);
			end
		end
	end

	// query: lowest way at the bottom of the stack, else way 0
	always_comb begin
		victim_d = '0;
		found    = 1'b0;
		for (int w = 0; w < ASSOC; w++) begin
			if (!found && (row_rd[w*PW +: PW] == PW'(ASSOC - 1))) begin
				victim_d = tlrus_pkg::WAY_W'(w);
				found    = 1'b1;
			end
		end
		if (!set_ok_s1) begin
			victim_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_s1 && (mode_s1 == tlrus_pkg::MODE_QUERY)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s1 && (mode_s1 == tlrus_pkg::MODE_QUERY)) begin
			victim_q <= victim_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign victim_way = victim_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == tlrus_pkg::ST_BUSY))
		else $error("accepted item did not enter the read-modify-write stage");

	a_write_touch: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && (state_q != tlrus_pkg::ST_CLEAR)) |->
			((mode_s1 == tlrus_pkg::MODE_TOUCH) && set_ok_s1 && way_ok))
		else $error("row written back by something other than a valid touch");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |->
			$past((state_q == tlrus_pkg::ST_BUSY) && (mode_s1 == tlrus_pkg::MODE_QUERY)))
		else $error("result appeared without a finishing query");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tlrus_pkg::ST_CLEAR) |=>
			!($past(in_xfer)) && ((state_q == tlrus_pkg::ST_CLEAR) ||
			(state_q == tlrus_pkg::ST_IDLE)))
		else $error("clearing pass left for a state other than idle");

endmodule

`default_nettype wire
